/* rtl/core/gn2t_pkg.sv */
// ----------------------------------------------------------------------------
// gn2t_pkg
// Shared types, constants and helpers of the tileable 2D gradient noise unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gn2t_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 24;
    localparam int INT_W      = COORD_W - FRAC_BITS;
    localparam int PERIOD_W   = 9;
    localparam int GRAD_W     = 16;
    localparam int NOISE_W    = 16;
    localparam int VAL_W      = 28;   // dot and lerp values, 22 fraction bits
    localparam int DIFF_W     = VAL_W + 1;
    localparam int FADE_W     = FRAC_BITS + 1;
    localparam int DOT_SHIFT  = 8;    // FRAC_BITS + 14 - 22

    localparam logic [1:0] MODE_EVAL = 2'd0;
    localparam logic [1:0] MODE_PERM = 2'd1;
    localparam logic [1:0] MODE_GRAD = 2'd2;

    localparam logic [FRAC_BITS+1:0] FADE_K = 18'(3 << FRAC_BITS);
    localparam logic [PERIOD_W-1:0]  PERIOD_FULL = PERIOD_W'(TABLE_SIZE);
    localparam logic signed [VAL_W-1:0] ROUND_HALF = VAL_W'(128);
    localparam logic signed [VAL_W-DOT_SHIFT-1:0] SAT_POS = 20'sd16384;
    localparam logic signed [VAL_W-DOT_SHIFT-1:0] SAT_NEG = -20'sd16384;

    typedef struct packed {
        logic [1:0]       mode;
        logic [IDX_W-1:0] idx;
        logic [7:0]       perm_value;
        logic [31:0]      grad;       // y in the upper half, x in the lower
    } ctl_t;

    typedef struct packed {
        logic [IDX_W-1:0] bx0;
        logic [IDX_W-1:0] bx1;
        logic [IDX_W-1:0] by0;
        logic [IDX_W-1:0] by1;
    } corner_t;

    // Four restoring steps of a remainder; rem stays below p (p <= TABLE_SIZE).
    function automatic logic [IDX_W-1:0] mod_step4(input logic [IDX_W-1:0] rem,
                                                   input logic [3:0] bits,
                                                   input logic [PERIOD_W-1:0] p);
        logic [IDX_W:0] r;
        r = {1'b0, rem};
        for (int k = 3; k >= 0; k--) begin
            r = {r[IDX_W-1:0], bits[k]};
            if (r >= p) begin
                r = r - p;
            end
        end
        return r[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/gn2t_point_if.sv */
// ----------------------------------------------------------------------------
// gn2t_point_if
// Input channel: one point evaluation or table write per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface gn2t_point_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [23:0]        x_coord;
    logic [23:0]        y_coord;
    logic [8:0]         period;
    logic [7:0]         table_index;
    logic [7:0]         perm_value;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;

    modport source (output valid, mode, x_coord, y_coord, period, table_index,
                    perm_value, grad_x, grad_y, input ready);
    modport sink   (input valid, mode, x_coord, y_coord, period, table_index,
                    perm_value, grad_x, grad_y, output ready);
endinterface

`default_nettype wire

/* rtl/core/gn2t_noise_if.sv */
// ----------------------------------------------------------------------------
// gn2t_noise_if
// Output channel: one noise sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface gn2t_noise_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/gn2t_corner.sv */
// ----------------------------------------------------------------------------
// gn2t_corner
// Two-stage lattice corner unit: integer parts modulo the tiling period.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2t_corner (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [gn2t_pkg::INT_W-1:0]    x_int,
    input  wire logic [gn2t_pkg::INT_W-1:0]    y_int,
    input  wire logic [gn2t_pkg::PERIOD_W-1:0] period,
    output gn2t_pkg::corner_t                  corner
);
    import gn2t_pkg::*;

    logic [IDX_W-1:0]    remx_reg, remy_reg;
    logic [3:0]          lowx_reg, lowy_reg;
    logic                wrapx_reg, wrapy_reg;
    logic [PERIOD_W-1:0] p_reg;
    corner_t             corner_reg;

    logic [PERIOD_W-1:0] p_eff;
    logic [IDX_W-1:0]    bx0, by0;
    logic [IDX_W:0]      bx_inc, by_inc;
    corner_t             corner_next;

    // zero or anything above the table size means no wrap
    assign p_eff = (period == '0 || period > PERIOD_FULL) ? PERIOD_FULL : period;

    always_comb
    begin
        bx0 = mod_step4(remx_reg, lowx_reg, p_reg);
        by0 = mod_step4(remy_reg, lowy_reg, p_reg);
        bx_inc = {1'b0, bx0} + 1'b1;
        by_inc = {1'b0, by0} + 1'b1;
        corner_next.bx0 = bx0;
        corner_next.by0 = by0;
        corner_next.bx1 = (wrapx_reg || bx_inc == p_reg) ? '0 : bx_inc[IDX_W-1:0];
        corner_next.by1 = (wrapy_reg || by_inc == p_reg) ? '0 : by_inc[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_reg   <= mod_step4('0, x_int[7:4], p_eff);
            remy_reg   <= mod_step4('0, y_int[7:4], p_eff);
            lowx_reg   <= x_int[3:0];
            lowy_reg   <= y_int[3:0];
            wrapx_reg  <= (x_int == '1);
            wrapy_reg  <= (y_int == '1);
            p_reg      <= p_eff;
            corner_reg <= corner_next;
        end
    end

    assign corner = corner_reg;

endmodule

`default_nettype wire

/* rtl/core/gradient_noise_2d_tileable_unit.sv */
// ----------------------------------------------------------------------------
// gradient_noise_2d_tileable_unit
// Tileable 2D Perlin gradient noise with loadable permutation and gradients.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the output is not stalled and
// returns one noise sample per transaction, in order. The datapath is a
// 13-stage pipeline with a single output register; the whole pipeline holds
// while a result waits on the output, so throughput is one point per cycle
// whenever the sink is ready. Mode 1 and mode 2 transactions load table
// entries and return zero; they take effect at the pipeline stage where each
// table copy is read, so evaluations always see exactly the writes sent
// before them. Tables come up undefined and must be loaded before use.
`default_nettype none

module gradient_noise_2d_tileable_unit (
    input wire logic    clk,
    input wire logic    rst_n,
    gn2t_point_if.sink  point,
    gn2t_noise_if.source noise
);
    import gn2t_pkg::*;

    localparam int NST = 13;

    logic                en;
    logic [NST:1]        vld_reg;
    ctl_t                ctl_reg [1:NST];
    logic                out_valid_reg;
    logic signed [NOISE_W-1:0] out_value_reg;

    // stage payloads
    logic [COORD_W-1:0]  x1_reg, y1_reg;
    logic [PERIOD_W-1:0] p1_reg;
    logic [FRAC_BITS-1:0] rx_reg [2:6];
    logic [FRAC_BITS-1:0] ry_reg [2:6];
    logic [FRAC_BITS-1:0] t2x_reg, t2y_reg;
    logic [FADE_W-1:0]   sx_reg [3:9];
    logic [FADE_W-1:0]   sy_reg [3:12];
    logic [IDX_W-1:0]    by0_reg, by1_reg;
    logic [IDX_W-1:0]    i_reg, j_reg;
    logic [IDX_W-1:0]    h00_reg, h10_reg, h01_reg, h11_reg;
    logic [31:0]         g00_reg, g10_reg, g01_reg, g11_reg;
    logic signed [32:0]  m_reg [0:7];
    logic signed [VAL_W-1:0] n00_reg, n10_reg, n01_reg, n11_reg;
    logic signed [VAL_W-1:0] a8_reg, c8_reg;
    logic signed [DIFF_W-1:0] dx0_reg, dx1_reg;
    logic signed [VAL_W-1:0] a9_reg, c9_reg;
    logic signed [DIFF_W+FADE_W:0] px0_reg, px1_reg;
    logic signed [VAL_W-1:0] a10_reg, b10_reg;
    logic signed [DIFF_W-1:0] d11_reg;
    logic signed [VAL_W-1:0] a11_reg, a12_reg;
    logic signed [DIFF_W+FADE_W:0] py_reg;

    // table copies, one per read stage pair
    logic [7:0]  perm_a [TABLE_SIZE];
    logic [7:0]  perm_b [TABLE_SIZE];
    logic [7:0]  perm_c [TABLE_SIZE];
    logic [31:0] grad_d [TABLE_SIZE];
    logic [31:0] grad_e [TABLE_SIZE];

    corner_t corner;
    ctl_t    ctl_in;

    assign en          = !out_valid_reg || noise.ready;
    assign point.ready = en;
    assign noise.valid = out_valid_reg;
    assign noise.noise_value = out_value_reg;

    always_comb
    begin
        ctl_in.mode       = point.mode;
        ctl_in.idx        = point.table_index[IDX_W-1:0];
        ctl_in.perm_value = point.perm_value;
        ctl_in.grad       = {point.grad_y, point.grad_x};
    end

    // ---------------- control: valid bits and output valid ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NST-1:1], point.valid};
            out_valid_reg <= vld_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[1] <= ctl_in;
            for (int k = 2; k <= NST; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // ---------------- stage 1 -> 2: fade square, corner modulo ----------------
    gn2t_corner u_corner (
        .clk    (clk),
        .en     (en),
        .x_int  (x1_reg[COORD_W-1:FRAC_BITS]),
        .y_int  (y1_reg[COORD_W-1:FRAC_BITS]),
        .period (p1_reg),
        .corner (corner)
    );

    logic [2*FRAC_BITS-1:0]   sqx, sqy;
    logic [2*FRAC_BITS+1:0]   fmx, fmy;

    always_comb
    begin
        sqx = x1_reg[FRAC_BITS-1:0] * x1_reg[FRAC_BITS-1:0];
        sqy = y1_reg[FRAC_BITS-1:0] * y1_reg[FRAC_BITS-1:0];
        fmx = t2x_reg * (FADE_K - {1'b0, rx_reg[2], 1'b0});
        fmy = t2y_reg * (FADE_K - {1'b0, ry_reg[2], 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= point.x_coord;
            y1_reg  <= point.y_coord;
            p1_reg  <= point.period;
            rx_reg[2] <= x1_reg[FRAC_BITS-1:0];
            ry_reg[2] <= y1_reg[FRAC_BITS-1:0];
            t2x_reg <= sqx[2*FRAC_BITS-1:FRAC_BITS];
            t2y_reg <= sqy[2*FRAC_BITS-1:FRAC_BITS];
            sx_reg[3] <= fmx[2*FRAC_BITS:FRAC_BITS];
            sy_reg[3] <= fmy[2*FRAC_BITS:FRAC_BITS];
            for (int k = 3; k <= 6; k++)
            begin
                rx_reg[k] <= rx_reg[k-1];
                ry_reg[k] <= ry_reg[k-1];
            end
            for (int k = 4; k <= 9; k++)
            begin
                sx_reg[k] <= sx_reg[k-1];
            end
            for (int k = 4; k <= 12; k++)
            begin
                sy_reg[k] <= sy_reg[k-1];
            end
        end
    end

    // ---------------- stage 3: first permutation lookup ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vld_reg[3] && ctl_reg[3].mode == MODE_PERM)
            begin
                perm_a[ctl_reg[3].idx] <= ctl_reg[3].perm_value;
            end
            i_reg   <= perm_a[corner.bx0];
            j_reg   <= perm_a[corner.bx1];
            by0_reg <= corner.by0;
            by1_reg <= corner.by1;
        end
    end

    // ---------------- stage 4: corner hashes ----------------
    logic [IDX_W-1:0] a00, a10, a01, a11;

    always_comb
    begin
        a00 = i_reg + by0_reg;
        a10 = j_reg + by0_reg;
        a01 = i_reg + by1_reg;
        a11 = j_reg + by1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vld_reg[4] && ctl_reg[4].mode == MODE_PERM)
            begin
                perm_b[ctl_reg[4].idx] <= ctl_reg[4].perm_value;
                perm_c[ctl_reg[4].idx] <= ctl_reg[4].perm_value;
            end
            h00_reg <= perm_b[a00];
            h10_reg <= perm_b[a10];
            h01_reg <= perm_c[a01];
            h11_reg <= perm_c[a11];
        end
    end

    // ---------------- stage 5: gradient lookup ----------------
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (vld_reg[5] && ctl_reg[5].mode == MODE_GRAD)
            begin
                grad_d[ctl_reg[5].idx] <= ctl_reg[5].grad;
                grad_e[ctl_reg[5].idx] <= ctl_reg[5].grad;
            end
            g00_reg <= grad_d[h00_reg];
            g10_reg <= grad_d[h10_reg];
            g01_reg <= grad_e[h01_reg];
            g11_reg <= grad_e[h11_reg];
        end
    end

    // ---------------- stage 6: dot product terms ----------------
    logic signed [FRAC_BITS:0] rx0, rx1, ry0, ry1;

    always_comb
    begin
        rx0 = $signed({1'b0, rx_reg[6]});
        rx1 = $signed({1'b1, rx_reg[6]});   // offset minus one
        ry0 = $signed({1'b0, ry_reg[6]});
        ry1 = $signed({1'b1, ry_reg[6]});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= $signed(g00_reg[15:0])  * rx0;
            m_reg[1] <= $signed(g00_reg[31:16]) * ry0;
            m_reg[2] <= $signed(g10_reg[15:0])  * rx1;
            m_reg[3] <= $signed(g10_reg[31:16]) * ry0;
            m_reg[4] <= $signed(g01_reg[15:0])  * rx0;
            m_reg[5] <= $signed(g01_reg[31:16]) * ry1;
            m_reg[6] <= $signed(g11_reg[15:0])  * rx1;
            m_reg[7] <= $signed(g11_reg[31:16]) * ry1;
        end
    end

    // ---------------- stage 7: dot sums ----------------
    logic signed [33:0] d00, d10, d01, d11;

    always_comb
    begin
        d00 = 34'(m_reg[0]) + 34'(m_reg[1]);
        d10 = 34'(m_reg[2]) + 34'(m_reg[3]);
        d01 = 34'(m_reg[4]) + 34'(m_reg[5]);
        d11 = 34'(m_reg[6]) + 34'(m_reg[7]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n00_reg <= VAL_W'(d00 >>> DOT_SHIFT);
            n10_reg <= VAL_W'(d10 >>> DOT_SHIFT);
            n01_reg <= VAL_W'(d01 >>> DOT_SHIFT);
            n11_reg <= VAL_W'(d11 >>> DOT_SHIFT);
        end
    end

    // ---------------- stages 8..13: bilinear blend ----------------
    logic signed [VAL_W-1:0] v13;
    logic signed [VAL_W-1:0] vr;
    logic signed [VAL_W-DOT_SHIFT-1:0] q;
    logic signed [NOISE_W-1:0] sat;

    always_comb
    begin
        v13 = a12_reg + VAL_W'(py_reg >>> FRAC_BITS);
        vr  = v13 + ROUND_HALF;
        q   = vr[VAL_W-1:DOT_SHIFT];
        if (q > SAT_POS)
        begin
            sat = NOISE_W'(SAT_POS);
        end
        else if (q < SAT_NEG)
        begin
            sat = NOISE_W'(SAT_NEG);
        end
        else
        begin
            sat = NOISE_W'(q);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a8_reg  <= n00_reg;
            c8_reg  <= n01_reg;
            dx0_reg <= DIFF_W'(n10_reg) - DIFF_W'(n00_reg);
            dx1_reg <= DIFF_W'(n11_reg) - DIFF_W'(n01_reg);

            a9_reg  <= a8_reg;
            c9_reg  <= c8_reg;
            px0_reg <= $signed({1'b0, sx_reg[9]}) * dx0_reg;
            px1_reg <= $signed({1'b0, sx_reg[9]}) * dx1_reg;

            a10_reg <= a9_reg + VAL_W'(px0_reg >>> FRAC_BITS);
            b10_reg <= c9_reg + VAL_W'(px1_reg >>> FRAC_BITS);

            a11_reg <= a10_reg;
            d11_reg <= DIFF_W'(b10_reg) - DIFF_W'(a10_reg);

            a12_reg <= a11_reg;
            py_reg  <= $signed({1'b0, sy_reg[12]}) * d11_reg;

            out_value_reg <= (ctl_reg[NST].mode == MODE_EVAL) ? sat : '0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/gn2t_checker.sv */
// ----------------------------------------------------------------------------
// gn2t_checker
// Port-level checks of the noise unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module gn2t_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [15:0] out_value
);

    // empty output register means the unit takes input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with output empty");

    // stalled output holds the whole pipeline
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while output stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_value <= 16'sd16384 && out_value >= -16'sd16384))
        else $error("noise out of range");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_value))
        else $error("output changed while stalled");

endmodule

bind gradient_noise_2d_tileable_unit gn2t_checker u_gn2t_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (noise.valid),
    .out_ready (noise.ready),
    .out_value (noise.noise_value)
);

`default_nettype wire
